// ===== rtl/core/wct_pkg.sv =====
// ----------------------------------------------------------------------------
// wct_pkg : shared types and constants for the window change trigger
// Sample widths, register codes, sequencer states and mean phases.
// ----------------------------------------------------------------------------
package wct_pkg;

   localparam int WCT_WINDOW_LEN   = 8;
   localparam int WCT_SAMPLE_W     = 16;
   localparam int WCT_PCT_W        = 10;
   localparam int WCT_DIR_W        = 2;
   localparam int WCT_PCT_SCALE    = 100;
   localparam int WCT_CSR_INDEX_W  = 2;
   localparam int WCT_CSR_DATA_W   = 10;

   localparam logic [WCT_CSR_INDEX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [WCT_CSR_INDEX_W-1:0] CSR_PERCENT   = 2'd1;

   localparam logic [WCT_DIR_W-1:0] DIR_EITHER = 2'b00;
   localparam logic [WCT_DIR_W-1:0] DIR_RISING = 2'b01;

   localparam logic [WCT_DIR_W-1:0] DIR_RESET = DIR_EITHER;
   localparam logic [WCT_PCT_W-1:0] PCT_RESET = 10'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_OFFSET,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_PRODUCT,
      ST_COMPARE,
      ST_FINISH
   } wct_state_type;

   typedef enum logic [1:0] {
      PH_WINDOW,
      PH_OLDER,
      PH_NEWER
   } wct_phase_type;

endpackage

// ===== rtl/core/wct_ring.sv =====
// ----------------------------------------------------------------------------
// wct_ring : sample ring storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wct_ring #(
   parameter int DEPTH  = wct_pkg::WCT_WINDOW_LEN,
   parameter int ADDR_W = 3
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [wct_pkg::WCT_SAMPLE_W-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [wct_pkg::WCT_SAMPLE_W-1:0] rd_data
);
   import wct_pkg::*;

   logic [WCT_SAMPLE_W-1:0] ring_mem [DEPTH];
   logic [WCT_SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wct_divider.sv =====
// ----------------------------------------------------------------------------
// wct_divider : divider by a fixed count
// Quotient of an offset sum by one of the fixed window counts, taken as the
// product with a scaled reciprocal shifted down by SHIFT. Exact for every
// dividend of DIVIDEND_W bits when SHIFT covers the dividend and count widths.
// The quotient is ready in the cycle after start, flagged by done.
// ----------------------------------------------------------------------------
module wct_divider #(
   parameter int DIVIDEND_W = 20,
   parameter int RECIP_W    = 25,
   parameter int SHIFT      = 24,
   parameter int QUOT_W     = wct_pkg::WCT_SAMPLE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [RECIP_W-1:0]    recip,
   output logic                  done,
   output logic [QUOT_W-1:0]     quotient
);
   localparam int PROD_W = DIVIDEND_W + RECIP_W;

   logic [PROD_W-1:0] prod_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(dividend) * PROD_W'(recip);
      end
   end

   assign done     = done_ff;
   assign quotient = prod_ff[SHIFT +: QUOT_W];

endmodule

// ===== rtl/core/window_change_trigger_top.sv =====
// ----------------------------------------------------------------------------
// window_change_trigger_top : moving window step change detector
// Each request beat appends one sample to a ring of the last WINDOW_LEN
// samples; each response beat gives the fill flag, the window average, the
// older and newer half averages and the change trigger.
//
// Request channel req_*: valid/stall, one sample per beat. Stall stays high
// from acceptance until the result has moved into the response register.
// Response channel rsp_*: valid/stall, exactly one beat per request beat.
// A stalled response holds; the next request is taken meanwhile and its
// result waits in the sequencer until the response register frees.
// Register port csr_*: index 0 direction, index 1 percent threshold; ready
// is high outside reset. Write only while idle.
// Sequence: while filling, one read of ring slot 0, then the response. Once
// full, WINDOW_LEN + 1 reads of the single ring read port, then three mean
// passes (offset, launch, divide) through the shared reciprocal multiplier
// plus a product and compare step. A new request is taken the cycle after
// the response loads.
// Reset (synchronous): window empty, direction 0, threshold 10 percent.
// ----------------------------------------------------------------------------
module window_change_trigger_top #(
   parameter int WINDOW_LEN = wct_pkg::WCT_WINDOW_LEN
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [wct_pkg::WCT_SAMPLE_W-1:0]    req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_window_full,
   output logic [wct_pkg::WCT_SAMPLE_W-1:0]    rsp_window_average,
   output logic [wct_pkg::WCT_SAMPLE_W-1:0]    rsp_older_half_average,
   output logic [wct_pkg::WCT_SAMPLE_W-1:0]    rsp_newer_half_average,
   output logic                               rsp_triggered,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wct_pkg::WCT_CSR_INDEX_W-1:0] csr_index,
   input  logic [wct_pkg::WCT_CSR_DATA_W-1:0]  csr_data
);
   import wct_pkg::*;

   localparam int ADDR_W    = $clog2(WINDOW_LEN);
   localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
   localparam int HALF_LEN  = WINDOW_LEN / 2;
   localparam int NEWER_LEN = WINDOW_LEN - HALF_LEN;
   localparam int SUM_W     = WCT_SAMPLE_W + CNT_W;
   localparam int PROD_W    = WCT_SAMPLE_W + WCT_PCT_W;
   localparam int SHIFT     = SUM_W + CNT_W;
   localparam int RECIP_W   = SHIFT + 1;
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_LEN - 1);
   localparam logic [RECIP_W-1:0] RECIP_WINDOW =
      RECIP_W'((64'd1 << SHIFT) / WINDOW_LEN + 1);
   localparam logic [RECIP_W-1:0] RECIP_OLDER =
      RECIP_W'((64'd1 << SHIFT) / HALF_LEN + 1);
   localparam logic [RECIP_W-1:0] RECIP_NEWER =
      RECIP_W'((64'd1 << SHIFT) / NEWER_LEN + 1);

   function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   wct_state_type state_ff, state_in;
   wct_phase_type phase_ff;

   logic [ADDR_W-1:0]       write_slot_ff, oldest_slot_ff, oldest_slot_in, ptr_ff;
   logic [CNT_W-1:0]        fill_count_ff, fill_count_in;
   logic                    full_ff, full_in, fill_room;
   logic [WCT_DIR_W-1:0]    direction_ff;
   logic [WCT_PCT_W-1:0]    percent_ff;
   logic [CNT_W-1:0]        iss_ff, last_ff, didx_ff;
   logic                    dv_ff;
   logic [SUM_W-1:0]        sum_old_ff, sum_new_ff;
   logic [WCT_SAMPLE_W-1:0] base0_ff, base_old_ff, base_new_ff;
   logic [SUM_W:0]          off_ff, off_in, off_neg;
   logic [SUM_W-1:0]        off_mag, tsel, cbase;
   logic                    neg_ff;
   logic [WCT_SAMPLE_W-1:0] bsel, mean_in;
   logic [CNT_W-1:0]        csel;
   logic [RECIP_W-1:0]      rsel;
   logic [WCT_SAMPLE_W-1:0] avg_ff, older_ff, newer_ff;
   logic [WCT_SAMPLE_W:0]   delta, delta_neg;
   logic [WCT_SAMPLE_W-1:0] dmag;
   logic [PROD_W-1:0]       lprod_ff, rprod_ff;
   logic                    fall_ff, rise_ff, trig_ff, trig_in, ge;
   logic                    rsp_valid_ff, rsp_full_ff, rsp_trig_ff;
   logic [WCT_SAMPLE_W-1:0] rsp_avg_ff, rsp_older_ff, rsp_newer_ff;

   logic                    accept, rd_en, div_start, load_rsp;
   logic                    div_done;
   logic [ADDR_W-1:0]       rd_addr;
   logic [WCT_SAMPLE_W-1:0] rd_data, div_quot;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = !reset;
   assign accept    = req_valid && !req_stall;

   // ring bookkeeping for the incoming sample
   assign fill_room      = fill_count_ff < CNT_W'(WINDOW_LEN);
   assign fill_count_in  = fill_room ? fill_count_ff + 1'b1 : fill_count_ff;
   assign oldest_slot_in = fill_room ? oldest_slot_ff : slot_inc(oldest_slot_ff);
   assign full_in        = fill_count_in == CNT_W'(WINDOW_LEN);

   wct_ring #(
      .DEPTH  (WINDOW_LEN),
      .ADDR_W (ADDR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (write_slot_ff),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wct_divider #(
      .DIVIDEND_W (SUM_W),
      .RECIP_W    (RECIP_W),
      .SHIFT      (SHIFT),
      .QUOT_W     (WCT_SAMPLE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_mag),
      .recip    (rsel),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rd_en     = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            rd_en = 1'b1;
            if (iss_ff == last_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = full_ff ? ST_OFFSET : ST_FINISH;
         end
         ST_OFFSET: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) state_in = (phase_ff == PH_NEWER) ? ST_PRODUCT : ST_OFFSET;
         end
         ST_PRODUCT: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rd_addr = (iss_ff == '0) ? '0 : ptr_ff;

   // control state: ring pointers, registers, read pipeline flag
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff  <= '0;
         oldest_slot_ff <= '0;
         fill_count_ff  <= '0;
         direction_ff   <= DIR_RESET;
         percent_ff     <= PCT_RESET;
         dv_ff          <= 1'b0;
      end else begin
         dv_ff <= rd_en;
         if (accept) begin
            write_slot_ff  <= slot_inc(write_slot_ff);
            oldest_slot_ff <= oldest_slot_in;
            fill_count_ff  <= fill_count_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIRECTION: direction_ff <= csr_data[WCT_DIR_W-1:0];
               CSR_PERCENT:   percent_ff   <= csr_data[WCT_PCT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // read sequence: slot 0 first, then the window from the oldest sample
   always_ff @(posedge clock) begin
      didx_ff <= iss_ff;
      if (accept) begin
         iss_ff     <= '0;
         last_ff    <= full_in ? CNT_W'(WINDOW_LEN) : '0;
         ptr_ff     <= oldest_slot_in;
         full_ff    <= full_in;
         phase_ff   <= PH_WINDOW;
         sum_old_ff <= '0;
         sum_new_ff <= '0;
      end else begin
         if (rd_en) begin
            iss_ff <= iss_ff + 1'b1;
            if (iss_ff != '0) ptr_ff <= slot_inc(ptr_ff);
         end
         if (dv_ff) begin
            if (didx_ff == '0) begin
               base0_ff <= rd_data;
            end else if (didx_ff <= CNT_W'(HALF_LEN)) begin
               sum_old_ff <= sum_old_ff + SUM_W'(rd_data);
               if (didx_ff == CNT_W'(1)) base_old_ff <= rd_data;
            end else begin
               sum_new_ff <= sum_new_ff + SUM_W'(rd_data);
               if (didx_ff == CNT_W'(HALF_LEN + 1)) base_new_ff <= rd_data;
            end
         end
         if (state_ff == ST_DIVIDE && div_done) begin
            case (phase_ff)
               PH_WINDOW: phase_ff <= PH_OLDER;
               PH_OLDER:  phase_ff <= PH_NEWER;
               default:   phase_ff <= PH_NEWER;
            endcase
         end
      end
   end

   // offset sum of the current mean: raw sum less count times baseline
   always_comb begin
      case (phase_ff)
         PH_WINDOW: begin
            tsel = sum_old_ff + sum_new_ff;
            bsel = base0_ff;
            csel = CNT_W'(WINDOW_LEN);
            rsel = RECIP_WINDOW;
         end
         PH_OLDER: begin
            tsel = sum_old_ff;
            bsel = base_old_ff;
            csel = CNT_W'(HALF_LEN);
            rsel = RECIP_OLDER;
         end
         default: begin
            tsel = sum_new_ff;
            bsel = base_new_ff;
            csel = CNT_W'(NEWER_LEN);
            rsel = RECIP_NEWER;
         end
      endcase
   end

   assign cbase   = SUM_W'(csel) * SUM_W'(bsel);
   assign off_in  = {1'b0, tsel} - {1'b0, cbase};
   assign off_neg = '0 - off_ff;
   assign off_mag = off_ff[SUM_W] ? off_neg[SUM_W-1:0] : off_ff[SUM_W-1:0];
   assign mean_in = bsel + (neg_ff ? (~div_quot + 1'b1) : div_quot);

   assign delta     = {1'b0, newer_ff} - {1'b0, older_ff};
   assign delta_neg = '0 - delta;
   assign dmag      = delta[WCT_SAMPLE_W] ? delta_neg[WCT_SAMPLE_W-1:0]
                                          : delta[WCT_SAMPLE_W-1:0];
   assign ge        = lprod_ff >= rprod_ff;

   always_comb begin
      case (direction_ff)
         DIR_EITHER: trig_in = ge;
         DIR_RISING: trig_in = ge && rise_ff;
         default:    trig_in = ge && fall_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OFFSET) off_ff <= off_in;
      if (div_start) neg_ff <= off_ff[SUM_W];
      if (state_ff == ST_DIVIDE && div_done) begin
         case (phase_ff)
            PH_WINDOW: avg_ff   <= mean_in;
            PH_OLDER:  older_ff <= mean_in;
            default:   newer_ff <= mean_in;
         endcase
      end
      if (state_ff == ST_PRODUCT) begin
         lprod_ff <= PROD_W'(dmag) * PROD_W'(WCT_PCT_SCALE);
         rprod_ff <= PROD_W'(older_ff) * PROD_W'(percent_ff);
         fall_ff  <= delta[WCT_SAMPLE_W];
         rise_ff  <= !delta[WCT_SAMPLE_W] && (delta != '0);
      end
      if (state_ff == ST_COMPARE) trig_ff <= trig_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_full_ff  <= full_ff;
         rsp_avg_ff   <= full_ff ? avg_ff : base0_ff;
         rsp_older_ff <= full_ff ? older_ff : '0;
         rsp_newer_ff <= full_ff ? newer_ff : '0;
         rsp_trig_ff  <= full_ff && trig_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_window_full        = rsp_full_ff;
   assign rsp_window_average     = rsp_avg_ff;
   assign rsp_older_half_average = rsp_older_ff;
   assign rsp_newer_half_average = rsp_newer_ff;
   assign rsp_triggered          = rsp_trig_ff;

   a_trig_needs_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_triggered |-> rsp_window_full)
      else $error("trigger reported before window full");

   a_halves_zero_filling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_full |->
         rsp_older_half_average == '0 && rsp_newer_half_average == '0)
      else $error("half averages non-zero while filling");

   a_full_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff == CNT_W'(WINDOW_LEN) |-> oldest_slot_ff == write_slot_ff)
      else $error("oldest and write slot disagree on a full ring");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_done)
      else $error("divider restarted before its quotient was taken");

endmodule
